@@ design/rcpf_pkg.sv @@
// Shared definitions for the robust cluster pose filter.
// Holds field widths, reset values, codes, the frame record type and the weight table.
// Depends on nothing; imported by the top level.
package rcpf_pkg;

    localparam int HISTORY_DEPTH_DEF  = 16;
    localparam int CLUSTER_SIZE_DEF   = 6;
    localparam int OUTLIER_PASSES_DEF = 3;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 16;

    localparam logic [CFG_AW-1:0] REG_SPEED_LIMIT  = 3'd0;
    localparam logic [CFG_AW-1:0] REG_OUTLIER_BASE = 3'd1;
    localparam logic [CFG_AW-1:0] REG_LEAD_SPEED   = 3'd2;
    localparam logic [CFG_AW-1:0] REG_VISION_DELAY = 3'd3;
    localparam logic [CFG_AW-1:0] REG_EXPIRY       = 3'd4;
    localparam logic [CFG_AW-1:0] REG_MIN_GAP      = 3'd5;
    localparam logic [CFG_AW-1:0] REG_PARK_X       = 3'd6;

    localparam logic [14:0] SPEED_LIMIT_RST  = 15'd6000;
    localparam logic [12:0] OUTLIER_BASE_RST = 13'd500;
    localparam logic [14:0] LEAD_SPEED_RST   = 15'd600;
    localparam logic [9:0]  VISION_DELAY_RST = 10'd0;
    localparam logic [15:0] EXPIRY_RST       = 16'd5000;
    localparam logic [7:0]  MIN_GAP_RST      = 8'd10;

    localparam logic FUNC_PUSH = 1'b0;
    localparam logic FUNC_EVAL = 1'b1;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_TOO_FEW  = 3'd1;
    localparam logic [2:0] ST_EXPIRED  = 3'd2;
    localparam logic [2:0] ST_NOTHING  = 3'd3;
    localparam logic [2:0] ST_NO_VALID = 3'd4;

    localparam logic signed [14:0] PARK_HEADING = -15'sd6434;

    typedef struct packed {
        logic signed [15:0] omega;
        logic signed [15:0] vel_y;
        logic signed [15:0] vel_x;
        logic signed [14:0] heading;
        logic signed [14:0] pos_y;
        logic signed [14:0] pos_x;
    } t_frame;

    function automatic logic [4:0] weight_pct(input logic [2:0] idx);
        logic [4:0] w;
        case (idx)
            3'd0: w = 5'd19;
            3'd1: w = 5'd18;
            3'd2: w = 5'd17;
            3'd3: w = 5'd13;
            3'd4: w = 5'd12;
            3'd5: w = 5'd11;
            3'd6: w = 5'd10;
            default: w = 5'd0;
        endcase
        return w;
    endfunction

endpackage

@@ design/robust_cluster_pose_filter_unit.sv @@
// Robust cluster pose filter: frame history, sequencer, shared multiplier and divider.
// Depends on rcpf_pkg for codes, widths, the frame type and the weight table.
//
// Use: words enter on i_in_valid/o_in_ready. A push word (func 0) stores a frame
// in the history ring and gives no result. An evaluate word (func 1)
// gives one result word on o_out_valid/i_out_ready.
// An evaluation that ends early (too few frames, expired, nothing new) passes
// through the check and emit states to its result and then takes a new word.
// A full evaluation scans the history for frames under the speed limit, forms the
// weighted mean and the errors of the cluster frames, runs the outlier passes,
// tests for position lead and divides. One 25 x 25 multiplier is shared by all
// products, and one radix-2 divider forms the five rounded means in turn.
// The block takes no new word until the current evaluation is finished.
// The result sits in an output register; while the receiver stalls, push words are
// still taken, and a following evaluation waits at its end for the register.
// Reset is synchronous and active low; it loads the default configuration, empties
// the history and zeroes the held pose. Configuration writes take effect at once.
module robust_cluster_pose_filter_unit #(
    parameter int HISTORY_DEPTH  = rcpf_pkg::HISTORY_DEPTH_DEF,
    parameter int CLUSTER_SIZE   = rcpf_pkg::CLUSTER_SIZE_DEF,
    parameter int OUTLIER_PASSES = rcpf_pkg::OUTLIER_PASSES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rcpf_pkg::CFG_AW-1:0] i_cfg_addr,
    input  logic [rcpf_pkg::CFG_DW-1:0] i_cfg_wdata,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_func,
    input  logic [31:0]                 i_time_ms,
    input  logic signed [14:0]          i_pos_x,
    input  logic signed [14:0]          i_pos_y,
    input  logic signed [14:0]          i_heading,
    input  logic signed [15:0]          i_vel_x,
    input  logic signed [15:0]          i_vel_y,
    input  logic signed [15:0]          i_omega,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [2:0]                  o_status,
    output logic signed [14:0]          o_out_x,
    output logic signed [14:0]          o_out_y,
    output logic signed [14:0]          o_out_heading,
    output logic signed [15:0]          o_out_vx,
    output logic signed [15:0]          o_out_vy,
    output logic signed [15:0]          o_out_omega,
    output logic [2:0]                  o_kept_count
);
    import rcpf_pkg::*;

    localparam int AW  = $clog2(HISTORY_DEPTH);
    localparam int CNW = $clog2(HISTORY_DEPTH + 1);
    localparam int IW  = (CLUSTER_SIZE > 1) ? $clog2(CLUSTER_SIZE) : 1;
    localparam int KW  = $clog2(CLUSTER_SIZE + 1);
    localparam int PW  = (OUTLIER_PASSES > 0) ? $clog2(OUTLIER_PASSES + 1) : 1;
    localparam int DW  = 30;

    localparam logic [5:0] S_IDLE   = 6'd0;
    localparam logic [5:0] S_CHECK  = 6'd1;
    localparam logic [5:0] S_LIM    = 6'd2;
    localparam logic [5:0] S_LIMW   = 6'd3;
    localparam logic [5:0] S_RD     = 6'd4;
    localparam logic [5:0] S_SQ1    = 6'd5;
    localparam logic [5:0] S_SQ2    = 6'd6;
    localparam logic [5:0] S_CMP    = 6'd7;
    localparam logic [5:0] S_MX     = 6'd8;
    localparam logic [5:0] S_MY     = 6'd9;
    localparam logic [5:0] S_MACC   = 6'd10;
    localparam logic [5:0] S_EX     = 6'd11;
    localparam logic [5:0] S_EY     = 6'd12;
    localparam logic [5:0] S_EACC   = 6'd13;
    localparam logic [5:0] S_WORST  = 6'd14;
    localparam logic [5:0] S_THR    = 6'd15;
    localparam logic [5:0] S_DROP   = 6'd16;
    localparam logic [5:0] S_SUM    = 6'd17;
    localparam logic [5:0] S_LK     = 6'd18;
    localparam logic [5:0] S_LK2    = 6'd19;
    localparam logic [5:0] S_SVX    = 6'd20;
    localparam logic [5:0] S_SVY    = 6'd21;
    localparam logic [5:0] S_LTEST  = 6'd22;
    localparam logic [5:0] S_NX1    = 6'd23;
    localparam logic [5:0] S_NX2    = 6'd24;
    localparam logic [5:0] S_NX3    = 6'd25;
    localparam logic [5:0] S_NY2    = 6'd26;
    localparam logic [5:0] S_NY3    = 6'd27;
    localparam logic [5:0] S_HD     = 6'd28;
    localparam logic [5:0] S_HCAP   = 6'd29;
    localparam logic [5:0] S_DSTART = 6'd30;
    localparam logic [5:0] S_DIV    = 6'd31;
    localparam logic [5:0] S_DEND   = 6'd32;
    localparam logic [5:0] S_POSE   = 6'd33;
    localparam logic [5:0] S_EMIT   = 6'd34;

    logic [5:0] r_state;

    logic [14:0]        r_speed_limit;
    logic [12:0]        r_outlier_base;
    logic [14:0]        r_lead_speed;
    logic [9:0]         r_vision_delay;
    logic [15:0]        r_expiry;
    logic [7:0]         r_min_gap;
    logic signed [14:0] r_park_x;

    logic [CNW-1:0] r_hist_count;
    logic [AW-1:0]  r_newest;
    logic [31:0]    r_last_frame;
    logic [31:0]    r_last_eval;
    logic           r_fresh;
    logic [31:0]    r_t;

    logic signed [14:0] r_px, r_py, r_ph;
    logic signed [15:0] r_pvx, r_pvy, r_pom;

    t_frame r_mem [HISTORY_DEPTH];
    t_frame r_rd;

    logic signed [15:0] r_cvx [CLUSTER_SIZE];
    logic signed [15:0] r_cvy [CLUSTER_SIZE];
    logic signed [15:0] r_com [CLUSTER_SIZE];
    logic signed [14:0] r_cx  [CLUSTER_SIZE];
    logic signed [14:0] r_cy  [CLUSTER_SIZE];
    logic [47:0]        r_err [CLUSTER_SIZE];
    logic [CLUSTER_SIZE-1:0] r_alive;

    logic [CNW-1:0] r_j;
    logic [KW-1:0]  r_n, r_i, r_k;
    logic [PW-1:0]  r_p;
    logic [IW-1:0]  r_worst;
    logic [47:0]    r_werr;
    logic           r_wv;

    logic signed [49:0] r_prod;
    logic [47:0]        r_acc;
    logic [31:0]        r_lim2;
    logic [47:0]        r_lk2;
    logic signed [23:0] r_mx, r_my;
    logic signed [18:0] r_svx, r_svy, r_som;
    logic signed [17:0] r_sx, r_sy;
    logic signed [29:0] r_numx, r_numy;
    logic [12:0]        r_div;
    logic signed [14:0] r_head;

    logic [2:0]         r_dsel;
    logic               r_dneg;
    logic [DW-1:0]      r_dq;
    logic [12:0]        r_rem;
    logic [12:0]        r_dsor;
    logic [4:0]         r_dcnt;
    logic signed [30:0] r_qx, r_qy;
    logic [15:0]        r_qvx, r_qvy, r_qom;

    logic [2:0] r_status;
    logic [2:0] r_kept;

    logic               r_out_valid;
    logic [2:0]         r_o_status, r_o_kept;
    logic signed [14:0] r_o_x, r_o_y, r_o_h;
    logic signed [15:0] r_o_vx, r_o_vy, r_o_om;

    logic               in_fire;
    logic [AW-1:0]      wr_slot, rd_slot;
    t_frame             in_frame;
    logic [IW-1:0]      idx;
    logic signed [15:0] cur_vx, cur_vy;
    logic signed [23:0] vx_ext, vy_ext, dx, dy;
    logic [24:0]        thr;
    logic signed [24:0] op_a, op_b;
    logic [31:0]        vsum;
    logic               hit;
    logic [KW-1:0]      n_n;
    logic [12:0]        k1000;
    logic signed [29:0] dnum;
    logic [12:0]        ddiv;
    logic [DW-1:0]      dmag;
    logic [13:0]        trial;
    logic               ge;
    logic signed [30:0] quot;
    logic [31:0]        since_frame, since_eval;
    logic               last_i;

    function automatic logic signed [14:0] sat15(input logic signed [30:0] v);
        logic signed [14:0] r;
        if (v > 31'sd16383) begin
            r = 15'sd16383;
        end else if (v < -31'sd16384) begin
            r = -15'sd16384;
        end else begin
            r = v[14:0];
        end
        return r;
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign in_fire    = i_in_valid && o_in_ready;

    assign in_frame.pos_x   = i_pos_x;
    assign in_frame.pos_y   = i_pos_y;
    assign in_frame.heading = i_heading;
    assign in_frame.vel_x   = i_vel_x;
    assign in_frame.vel_y   = i_vel_y;
    assign in_frame.omega   = i_omega;

    assign wr_slot = (r_newest == AW'(HISTORY_DEPTH - 1)) ? '0 : r_newest + 1'b1;

    always_comb begin
        if (r_state == S_HD) begin
            rd_slot = r_newest;
        end else if (32'(r_newest) >= 32'(r_j)) begin
            rd_slot = AW'(32'(r_newest) - 32'(r_j));
        end else begin
            rd_slot = AW'(32'(r_newest) + 32'(HISTORY_DEPTH) - 32'(r_j));
        end
    end

    assign idx    = r_i[IW-1:0];
    assign cur_vx = r_cvx[idx];
    assign cur_vy = r_cvy[idx];
    assign vx_ext = 24'(cur_vx);
    assign vy_ext = 24'(cur_vy);
    assign dx     = (vx_ext <<< 6) + (vx_ext <<< 5) + (vx_ext <<< 2) - r_mx;
    assign dy     = (vy_ext <<< 6) + (vy_ext <<< 5) + (vy_ext <<< 2) - r_my;
    assign thr    = (25'(r_outlier_base) * 25'd100) << r_p;
    assign k1000  = 13'(r_k) * 13'd1000;
    assign last_i = (32'(r_i) + 32'd1 == 32'(r_n));

    assign vsum  = r_acc[31:0] + r_prod[31:0];
    assign hit   = (vsum < r_lim2);
    assign n_n   = r_n + KW'(hit);

    assign since_frame = r_t - r_last_frame;
    assign since_eval  = r_t - r_last_eval;

    always_comb begin
        op_a = '0;
        op_b = '0;
        case (r_state)
            S_LIM: begin
                op_a = 25'(r_speed_limit);
                op_b = 25'(r_speed_limit);
            end
            S_SQ1: begin
                op_a = 25'(r_rd.vel_x);
                op_b = 25'(r_rd.vel_x);
            end
            S_SQ2: begin
                op_a = 25'(r_rd.vel_y);
                op_b = 25'(r_rd.vel_y);
            end
            S_MX: begin
                op_a = 25'(cur_vx);
                op_b = 25'(weight_pct(3'(r_i)));
            end
            S_MY: begin
                op_a = 25'(cur_vy);
                op_b = 25'(weight_pct(3'(r_i)));
            end
            S_EX: begin
                op_a = 25'(dx);
                op_b = 25'(dx);
            end
            S_EY: begin
                op_a = 25'(dy);
                op_b = 25'(dy);
            end
            S_THR: begin
                op_a = thr;
                op_b = thr;
            end
            S_LK: begin
                op_a = 25'(r_lead_speed);
                op_b = 25'(r_k);
            end
            S_LK2: begin
                op_a = 25'(r_prod[17:0]);
                op_b = 25'(r_prod[17:0]);
            end
            S_SVX: begin
                op_a = 25'(r_svx);
                op_b = 25'(r_svx);
            end
            S_SVY: begin
                op_a = 25'(r_svy);
                op_b = 25'(r_svy);
            end
            S_NX1: begin
                op_a = 25'(r_sx);
                op_b = 25'd1000;
            end
            S_NX2: begin
                op_a = 25'(r_svx);
                op_b = 25'(r_vision_delay);
            end
            S_NX3: begin
                op_a = 25'(r_sy);
                op_b = 25'd1000;
            end
            S_NY2: begin
                op_a = 25'(r_svy);
                op_b = 25'(r_vision_delay);
            end
            default: begin
                op_a = '0;
                op_b = '0;
            end
        endcase
    end

    always_comb begin
        case (r_dsel)
            3'd0:    dnum = r_numx;
            3'd1:    dnum = r_numy;
            3'd2:    dnum = 30'(r_svx);
            3'd3:    dnum = 30'(r_svy);
            default: dnum = 30'(r_som);
        endcase
        ddiv  = (r_dsel < 3'd2) ? r_div : 13'(r_k);
        dmag  = (dnum < 0) ? DW'(-dnum) + DW'(ddiv >> 1) : DW'(dnum) + DW'(ddiv >> 1);
        trial = {r_rem, r_dq[DW-1]};
        ge    = (trial >= {1'b0, r_dsor});
        quot  = r_dneg ? -$signed({1'b0, r_dq}) : $signed({1'b0, r_dq});
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && i_func == FUNC_PUSH) begin
            r_mem[wr_slot] <= in_frame;
        end
        if (r_state == S_RD || r_state == S_HD) begin
            r_rd <= r_mem[rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= op_a * op_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_speed_limit  <= SPEED_LIMIT_RST;
            r_outlier_base <= OUTLIER_BASE_RST;
            r_lead_speed   <= LEAD_SPEED_RST;
            r_vision_delay <= VISION_DELAY_RST;
            r_expiry       <= EXPIRY_RST;
            r_min_gap      <= MIN_GAP_RST;
            r_park_x       <= '0;
            r_hist_count   <= '0;
            r_newest       <= '0;
            r_last_frame   <= '0;
            r_last_eval    <= '0;
            r_fresh        <= 1'b0;
            r_px           <= '0;
            r_py           <= '0;
            r_ph           <= '0;
            r_pvx          <= '0;
            r_pvy          <= '0;
            r_pom          <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_SPEED_LIMIT:  r_speed_limit  <= i_cfg_wdata[14:0];
                    REG_OUTLIER_BASE: r_outlier_base <= i_cfg_wdata[12:0];
                    REG_LEAD_SPEED:   r_lead_speed   <= i_cfg_wdata[14:0];
                    REG_VISION_DELAY: r_vision_delay <= i_cfg_wdata[9:0];
                    REG_EXPIRY:       r_expiry       <= i_cfg_wdata[15:0];
                    REG_MIN_GAP:      r_min_gap      <= i_cfg_wdata[7:0];
                    REG_PARK_X:       r_park_x       <= i_cfg_wdata[14:0];
                    default: ;
                endcase
            end

            if (r_out_valid && i_out_ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        r_t <= i_time_ms;
                        if (i_func == FUNC_PUSH) begin
                            r_newest     <= wr_slot;
                            r_last_frame <= i_time_ms;
                            r_fresh      <= 1'b1;
                            if (32'(r_hist_count) < 32'(HISTORY_DEPTH)) begin
                                r_hist_count <= r_hist_count + 1'b1;
                            end
                        end else begin
                            r_state <= S_CHECK;
                        end
                    end
                end
                S_CHECK: begin
                    r_kept <= '0;
                    if (32'(r_hist_count) < 32'd2) begin
                        r_status <= ST_TOO_FEW;
                        r_state  <= S_EMIT;
                    end else if (since_frame > 32'(r_expiry)) begin
                        r_hist_count <= '0;
                        r_px         <= r_park_x;
                        r_ph         <= PARK_HEADING;
                        r_pvx        <= '0;
                        r_pvy        <= '0;
                        r_pom        <= '0;
                        r_status     <= ST_EXPIRED;
                        r_state      <= S_EMIT;
                    end else if (!r_fresh && since_eval < 32'(r_min_gap)) begin
                        r_status <= ST_NOTHING;
                        r_state  <= S_EMIT;
                    end else begin
                        r_last_eval <= r_t;
                        r_fresh     <= 1'b0;
                        r_j         <= '0;
                        r_n         <= '0;
                        r_state     <= S_LIM;
                    end
                end
                S_LIM: begin
                    r_state <= S_LIMW;
                end
                S_LIMW: begin
                    r_lim2  <= r_prod[31:0];
                    r_state <= S_RD;
                end
                S_RD: begin
                    r_state <= S_SQ1;
                end
                S_SQ1: begin
                    r_state <= S_SQ2;
                end
                S_SQ2: begin
                    r_acc   <= r_prod[47:0];
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    if (hit) begin
                        r_cvx[r_n[IW-1:0]]   <= r_rd.vel_x;
                        r_cvy[r_n[IW-1:0]]   <= r_rd.vel_y;
                        r_com[r_n[IW-1:0]]   <= r_rd.omega;
                        r_cx[r_n[IW-1:0]]    <= r_rd.pos_x;
                        r_cy[r_n[IW-1:0]]    <= r_rd.pos_y;
                        r_alive[r_n[IW-1:0]] <= 1'b1;
                    end
                    r_n <= n_n;
                    r_j <= r_j + 1'b1;
                    if ((32'(r_j) + 32'd1 < 32'(r_hist_count)) &&
                        (32'(n_n) < 32'(CLUSTER_SIZE))) begin
                        r_state <= S_RD;
                    end else if (n_n == '0) begin
                        r_status <= ST_NO_VALID;
                        r_state  <= S_EMIT;
                    end else begin
                        r_i     <= '0;
                        r_mx    <= '0;
                        r_my    <= '0;
                        r_state <= S_MX;
                    end
                end
                S_MX: begin
                    r_state <= S_MY;
                end
                S_MY: begin
                    r_mx    <= r_mx + $signed(r_prod[23:0]);
                    r_state <= S_MACC;
                end
                S_MACC: begin
                    r_my <= r_my + $signed(r_prod[23:0]);
                    if (last_i) begin
                        r_i     <= '0;
                        r_state <= S_EX;
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_MX;
                    end
                end
                S_EX: begin
                    r_state <= S_EY;
                end
                S_EY: begin
                    r_acc   <= r_prod[47:0];
                    r_state <= S_EACC;
                end
                S_EACC: begin
                    r_err[idx] <= r_acc + r_prod[47:0];
                    if (last_i) begin
                        r_i  <= '0;
                        r_k  <= r_n;
                        r_p  <= '0;
                        r_wv <= 1'b0;
                        if (OUTLIER_PASSES > 0 && 32'(r_n) > 32'd1) begin
                            r_state <= S_WORST;
                        end else begin
                            r_svx   <= '0;
                            r_svy   <= '0;
                            r_som   <= '0;
                            r_sx    <= '0;
                            r_sy    <= '0;
                            r_state <= S_SUM;
                        end
                    end else begin
                        r_i     <= r_i + 1'b1;
                        r_state <= S_EX;
                    end
                end
                S_WORST: begin
                    if (r_alive[idx] && (!r_wv || r_err[idx] > r_werr)) begin
                        r_worst <= idx;
                        r_werr  <= r_err[idx];
                        r_wv    <= 1'b1;
                    end
                    if (last_i) begin
                        r_i     <= '0;
                        r_state <= S_THR;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_THR: begin
                    r_state <= S_DROP;
                end
                S_DROP: begin
                    if (r_werr > r_prod[47:0]) begin
                        r_alive[r_worst] <= 1'b0;
                        r_k              <= r_k - 1'b1;
                    end
                    if (r_werr > r_prod[47:0] &&
                        32'(r_p) + 32'd1 < 32'(OUTLIER_PASSES) && 32'(r_k) > 32'd2) begin
                        r_p     <= r_p + 1'b1;
                        r_wv    <= 1'b0;
                        r_state <= S_WORST;
                    end else begin
                        r_svx   <= '0;
                        r_svy   <= '0;
                        r_som   <= '0;
                        r_sx    <= '0;
                        r_sy    <= '0;
                        r_state <= S_SUM;
                    end
                end
                S_SUM: begin
                    if (r_alive[idx]) begin
                        r_svx <= r_svx + 19'(cur_vx);
                        r_svy <= r_svy + 19'(cur_vy);
                        r_som <= r_som + 19'(r_com[idx]);
                        r_sx  <= r_sx + 18'(r_cx[idx]);
                        r_sy  <= r_sy + 18'(r_cy[idx]);
                    end
                    if (last_i) begin
                        r_state <= S_LK;
                    end else begin
                        r_i <= r_i + 1'b1;
                    end
                end
                S_LK: begin
                    r_state <= S_LK2;
                end
                S_LK2: begin
                    r_state <= S_SVX;
                end
                S_SVX: begin
                    r_lk2   <= r_prod[47:0];
                    r_state <= S_SVY;
                end
                S_SVY: begin
                    r_acc   <= r_prod[47:0];
                    r_state <= S_LTEST;
                end
                S_LTEST: begin
                    if (r_acc + r_prod[47:0] > r_lk2) begin
                        r_div   <= k1000;
                        r_state <= S_NX1;
                    end else begin
                        r_numx  <= 30'(r_sx);
                        r_numy  <= 30'(r_sy);
                        r_div   <= 13'(r_k);
                        r_state <= S_HD;
                    end
                end
                S_NX1: begin
                    r_state <= S_NX2;
                end
                S_NX2: begin
                    r_acc   <= r_prod[47:0];
                    r_state <= S_NX3;
                end
                S_NX3: begin
                    r_numx  <= $signed(r_acc[29:0] + r_prod[29:0]);
                    r_state <= S_NY2;
                end
                S_NY2: begin
                    r_acc   <= r_prod[47:0];
                    r_state <= S_NY3;
                end
                S_NY3: begin
                    r_numy  <= $signed(r_acc[29:0] + r_prod[29:0]);
                    r_state <= S_HD;
                end
                S_HD: begin
                    r_state <= S_HCAP;
                end
                S_HCAP: begin
                    r_head  <= r_rd.heading;
                    r_dsel  <= '0;
                    r_state <= S_DSTART;
                end
                S_DSTART: begin
                    r_dneg  <= (dnum < 0);
                    r_dq    <= dmag;
                    r_dsor  <= ddiv;
                    r_rem   <= '0;
                    r_dcnt  <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_rem  <= ge ? 13'(trial - {1'b0, r_dsor}) : trial[12:0];
                    r_dq   <= {r_dq[DW-2:0], ge};
                    r_dcnt <= r_dcnt + 1'b1;
                    if (r_dcnt == 5'(DW - 1)) begin
                        r_state <= S_DEND;
                    end
                end
                S_DEND: begin
                    case (r_dsel)
                        3'd0:    r_qx  <= quot;
                        3'd1:    r_qy  <= quot;
                        3'd2:    r_qvx <= quot[15:0];
                        3'd3:    r_qvy <= quot[15:0];
                        default: r_qom <= quot[15:0];
                    endcase
                    if (r_dsel == 3'd4) begin
                        r_state <= S_POSE;
                    end else begin
                        r_dsel  <= r_dsel + 1'b1;
                        r_state <= S_DSTART;
                    end
                end
                S_POSE: begin
                    r_px     <= sat15(r_qx);
                    r_py     <= sat15(r_qy);
                    r_ph     <= r_head;
                    r_pvx    <= r_qvx;
                    r_pvy    <= r_qvy;
                    r_pom    <= r_qom;
                    r_status <= ST_OK;
                    r_kept   <= 3'(r_k);
                    r_state  <= S_EMIT;
                end
                S_EMIT: begin
                    if (!r_out_valid || i_out_ready) begin
                        r_out_valid <= 1'b1;
                        r_o_status  <= r_status;
                        r_o_kept    <= r_kept;
                        r_o_x       <= r_px;
                        r_o_y       <= r_py;
                        r_o_h       <= r_ph;
                        r_o_vx      <= r_pvx;
                        r_o_vy      <= r_pvy;
                        r_o_om      <= r_pom;
                        r_state     <= S_IDLE;
                    end else begin
                        r_out_valid <= 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_o_status;
    assign o_out_x       = r_o_x;
    assign o_out_y       = r_o_y;
    assign o_out_heading = r_o_h;
    assign o_out_vx      = r_o_vx;
    assign o_out_vy      = r_o_vy;
    assign o_out_omega   = r_o_om;
    assign o_kept_count  = r_o_kept;

endmodule
